[sv/chacha20_stream_cipher_core_macros.svh]
// Assertion macros shared by the cipher RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef CHACHA20_STREAM_CIPHER_CORE_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_CORE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define CC20_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define CC20_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[sv/cc20_pkg.sv]
// Shared types and constants of the ChaCha20 byte cipher.
// Depends on nothing; used by every RTL file of the block.
package cc20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUND_W       = $clog2(DOUBLE_ROUNDS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // One 64-byte block as sixteen 32-bit words.
    typedef logic [15:0][31:0] block_t;

    // The words of "expand 32-byte k".
    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_KEY0  = 3'd0,
        CFG_KEY1  = 3'd1,
        CFG_KEY2  = 3'd2,
        CFG_KEY3  = 3'd3,
        CFG_NONCE = 3'd4
    } cfg_index_t;

    // Value of the byte position that marks the keystream buffer empty.
    localparam logic [6:0] POS_EMPTY = 7'd64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_word_t;

endpackage

[sv/cc20_fifo.sv]
// Input word queue that decouples acceptance from keystream work.
// Depends on cc20_pkg for the word type and queue depth.
module cc20_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cc20_pkg::in_word_t push_word,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output cc20_pkg::in_word_t head_word
);

    cc20_pkg::in_word_t                 entry_reg [cc20_pkg::QUEUE_DEPTH];
    logic [cc20_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [cc20_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [cc20_pkg::QCNT_W-1:0]        count_reg, count_next;

    assign full      = (count_reg == cc20_pkg::QCNT_W'(cc20_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_word = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == cc20_pkg::QPTR_W'(cc20_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == cc20_pkg::QPTR_W'(cc20_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[sv/cc20_keygen.sv]
// Keystream block generator: one shared half-quarter-round unit; each phase does one half of a quarter round.
// Depends on cc20_pkg for the block type and the round count.
module cc20_keygen
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cc20_pkg::block_t init,
    output logic             done,
    output cc20_pkg::block_t keystream
);

    typedef enum logic [1:0] {
        KG_IDLE,
        KG_ROUND,
        KG_FEED
    } kg_state_t;

    kg_state_t                      state_reg;
    logic                           phase_reg;
    logic [2:0]                     step_reg;
    logic [cc20_pkg::ROUND_W-1:0]   round_reg;
    logic                           done_reg;
    cc20_pkg::block_t               work_reg;
    cc20_pkg::block_t               ks_reg;

    logic [31:0]      qa, qb, qc, qd, qd_x, qb_x;
    cc20_pkg::block_t mixed;
    cc20_pkg::block_t shifted;
    logic [1:0]       amt [4];

    assign done      = done_reg;
    assign keystream = ks_reg;

    // Half a quarter round on column 0; the phase picks the rotation pair.
    always_comb
    begin
        qa    = work_reg[0] + work_reg[4];
        qd_x  = work_reg[12] ^ qa;
        qd    = phase_reg ? {qd_x[23:0], qd_x[31:24]} : {qd_x[15:0], qd_x[31:16]};
        qc    = work_reg[8] + qd;
        qb_x  = work_reg[4] ^ qc;
        qb    = phase_reg ? {qb_x[24:0], qb_x[31:25]} : {qb_x[19:0], qb_x[31:20]};
        mixed     = work_reg;
        mixed[0]  = qa;
        mixed[4]  = qb;
        mixed[8]  = qc;
        mixed[12] = qd;
    end

    // Rotate each row left so the next column lands in column 0. After the
    // fourth column step the rows also move into diagonal order, and after
    // the fourth diagonal step they move back.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            if (step_reg == 3'd3)
            begin
                amt[r] = 2'd1 + 2'(r);
            end
            else if (step_reg == 3'd7)
            begin
                amt[r] = 2'd1 - 2'(r);
            end
            else
            begin
                amt[r] = 2'd1;
            end
            for (int j = 0; j < 4; j++)
            begin
                shifted[{2'(r), 2'(j)}] = mixed[{2'(r), 2'(2'(j) + amt[r])}];
            end
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KG_IDLE;
            phase_reg <= 1'b0;
            step_reg  <= '0;
            round_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == KG_FEED);
            unique case (state_reg)
                KG_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= 1'b0;
                        step_reg  <= '0;
                        round_reg <= '0;
                        state_reg <= KG_ROUND;
                    end
                end
                KG_ROUND:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == 3'd7)
                        begin
                            if (round_reg ==
                                cc20_pkg::ROUND_W'(cc20_pkg::DOUBLE_ROUNDS - 1))
                            begin
                                state_reg <= KG_FEED;
                            end
                            else
                            begin
                                round_reg <= round_reg + 1'b1;
                            end
                        end
                    end
                end
                KG_FEED:
                begin
                    state_reg <= KG_IDLE;
                end
                default:
                begin
                    state_reg <= KG_IDLE;
                end
            endcase
        end
    end

    // Working state and feed-forward result.
    always_ff @(posedge clk)
    begin
        if (state_reg == KG_IDLE && start)
        begin
            work_reg <= init;
        end
        else if (state_reg == KG_ROUND)
        begin
            work_reg <= phase_reg ? shifted : mixed;
        end
        if (state_reg == KG_FEED)
        begin
            for (int i = 0; i < 16; i++)
            begin
                ks_reg[i] <= work_reg[i] + init[i];
            end
        end
    end

endmodule

[sv/chacha20_stream_cipher_core.sv]
// ChaCha20 byte cipher. Path: a byte taken passes through the input queue and the output
// register when the keystream buffer holds bytes; a byte that needs a new block also waits
// while the generator runs its double rounds and feed-forward. Throughput: one byte a cycle
// from the buffer while out_ready holds; each new 64-byte block uses the single shared unit.
// Reset: keys, nonce and counter clear, the keystream buffer is empty, queue and output
// are empty.
`include "chacha20_stream_cipher_core_macros.svh"

module chacha20_stream_cipher_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cc20_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cc20_pkg::out_word_t out_data,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    logic [3:0][63:0]    key_reg, key_next;
    logic [63:0]         nonce_reg, nonce_next;
    logic [63:0]         cnt_low_reg, cnt_high_reg;
    logic [6:0]          pos_reg;
    logic                gen_busy_reg;
    logic                out_valid_reg;
    cc20_pkg::out_word_t out_data_reg;
    logic                reinit;

    logic                q_full, q_empty, q_pop;
    cc20_pkg::in_word_t  head_word;
    logic                gen_start, gen_done;
    cc20_pkg::block_t    init_words, ks_words;
    logic                out_free;
    logic [7:0]          ks_byte;

    assign in_ready  = !q_full;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Front: incoming words wait in a short queue.
    cc20_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_word (in_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_word (head_word)
    );

    // Block input words: constant, key, counter and nonce words.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init_words[i]         = cc20_pkg::SIGMA[i];
            init_words[4 + 2 * i] = key_reg[i][31:0];
            init_words[5 + 2 * i] = key_reg[i][63:32];
        end
        init_words[12] = cnt_low_reg[31:0];
        init_words[13] = cnt_low_reg[63:32];
        init_words[14] = cnt_high_reg[31:0];
        init_words[15] = cnt_high_reg[63:32];
    end

    cc20_keygen u_keygen
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (gen_start),
        .init      (init_words),
        .done      (gen_done),
        .keystream (ks_words)
    );

    // Back: refill the buffer when empty, otherwise transform the head word.
    assign out_free  = !out_valid_reg || out_ready;
    assign gen_start = !q_empty && !gen_busy_reg && (pos_reg == cc20_pkg::POS_EMPTY);
    assign q_pop     = !q_empty && !gen_busy_reg && (pos_reg != cc20_pkg::POS_EMPTY)
                       && out_free;
    assign ks_byte   = ks_words[pos_reg[5:2]][{pos_reg[1:0], 3'b000} +: 8];

    // Configuration decode; any write to a key or nonce index restarts the stream.
    always_comb
    begin
        key_next   = key_reg;
        nonce_next = nonce_reg;
        reinit     = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cc20_pkg::CFG_KEY0, cc20_pkg::CFG_KEY1,
                cc20_pkg::CFG_KEY2, cc20_pkg::CFG_KEY3:
                begin
                    key_next[cfg_index[1:0]] = cfg_data;
                    reinit                   = 1'b1;
                end
                cc20_pkg::CFG_NONCE:
                begin
                    nonce_next = cfg_data;
                    reinit     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and counter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            nonce_reg     <= '0;
            cnt_low_reg   <= '0;
            cnt_high_reg  <= '0;
            pos_reg       <= cc20_pkg::POS_EMPTY;
            gen_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_reg   <= key_next;
            nonce_reg <= nonce_next;
            if (reinit)
            begin
                cnt_low_reg  <= '0;
                cnt_high_reg <= nonce_next;
                pos_reg      <= cc20_pkg::POS_EMPTY;
            end
            else if (gen_done)
            begin
                cnt_low_reg <= cnt_low_reg + 64'd1;
                if (cnt_low_reg == '1)
                begin
                    cnt_high_reg <= cnt_high_reg + 64'd1;
                end
                pos_reg <= '0;
            end
            else if (q_pop)
            begin
                pos_reg <= head_word.last_byte ? cc20_pkg::POS_EMPTY : pos_reg + 7'd1;
            end
            if (gen_start)
            begin
                gen_busy_reg <= 1'b1;
            end
            else if (gen_done)
            begin
                gen_busy_reg <= 1'b0;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg.out_byte <= head_word.data_byte ^ ks_byte;
            out_data_reg.out_last <= head_word.last_byte;
        end
    end

    `CC20_ASSERT_NOW(a_pop_needs_keystream, clk, rst_n, q_pop,
        pos_reg != cc20_pkg::POS_EMPTY && !gen_busy_reg, "byte taken without keystream")
    `CC20_ASSERT_NEXT(a_start_sets_busy, clk, rst_n, gen_start && !reinit, gen_busy_reg,
        "block generation start not recorded")
    `CC20_ASSERT_NEXT(a_done_fills_buffer, clk, rst_n, gen_done && !reinit, pos_reg == 7'd0,
        "finished block did not reset the byte position")
    `CC20_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && !out_ready,
        out_valid_reg && $stable(out_data_reg), "stalled output word changed")

endmodule
